// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. Empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- rtl/core/spre_pkg.sv -----
// ---------------------------------------------------------------------------
// spre_pkg
// Types and constants of the shortest-path relaxation engine.
// ---------------------------------------------------------------------------
package spre_pkg;

  localparam int unsigned DEF_MAX_NODES   = 32;
  localparam int unsigned DEF_MAX_EDGES   = 256;
  localparam int unsigned DEF_WEIGHT_BITS = 16;

  localparam int unsigned NODE_W      = 5;
  localparam int unsigned DIST_W      = 22;
  localparam int unsigned WEIGHT_IN_W = 16;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned OUT_USER_W = 3;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - NODE_W - DIST_W;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 6;

  localparam logic [CFG_DATA_W-1:0] NODE_COUNT_RST  = 6'd32;
  localparam logic [NODE_W-1:0]     SOURCE_NODE_RST = 5'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NODE_COUNT  = 1'b0,
    REG_SOURCE_NODE = 1'b1
  } spre_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_EDGE,
    S_RD_DIST,
    S_UPD,
    S_NEG,
    S_OUT_RD,
    S_OUT_LD
  } spre_state_e;

  typedef struct packed {
    logic [NODE_W-1:0] index;
    logic [DIST_W-1:0] distance;
    logic              reached;
    logic              neg;
    logic              dropped;
    logic              last;
  } spre_result_t;

endpackage

// ----- rtl/core/spre_ram.sv -----
// ---------------------------------------------------------------------------
// spre_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module spre_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/shortest_path_relaxation_engine.sv -----
// ---------------------------------------------------------------------------
// shortest_path_relaxation_engine
// Bellman-Ford single-source shortest paths over a stored edge list.
// ---------------------------------------------------------------------------
// Edges arrive on the s_axis channel, one transfer each; the store takes one
// per cycle while idle and sets a drop flag if an edge arrives with MAX_EDGES
// already held. The transfer with tlast set carries the final edge and starts
// a run. Input is held off (s_axis_tready low) until the run has loaded its
// last result for output. A run relaxes every stored edge for nodes-1 rounds
// and then makes a check pass. Each edge steps through the edge read, distance
// read and update states, as the edge and distance memories have registered
// reads; each reported node passes an output read and an output load state.
// Results leave on m_axis: either one negative-cycle result, or one result
// per node 0..nodes-1, the final one with tlast set. A single output register
// holds a result until m_axis_tready; while it is stalled the engine waits,
// and the next run's edges may be accepted while the last result waits.
// Registers (node_count, source_node) are written over the cfg channel, which
// is always ready. Reset clears the edge count, drop flag, reached bits and
// output valid; memories need no clearing.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module shortest_path_relaxation_engine import spre_pkg::*; #(
  parameter int unsigned MAX_NODES   = DEF_MAX_NODES,
  parameter int unsigned MAX_EDGES   = DEF_MAX_EDGES,
  parameter int unsigned WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // edge_from [4:0], edge_to [9:5], edge_weight [25:10], zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tlast,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // node_index [4:0], distance [26:5], zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // reached [0], negative_cycle [1], edges_dropped [2]
  output logic [OUT_USER_W-1:0] m_axis_tuser,
  output logic                  m_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned NodeW     = $clog2(MAX_NODES);
  localparam int unsigned CntW      = ($clog2(MAX_NODES + 1) > CFG_DATA_W) ?
                                      $clog2(MAX_NODES + 1) : CFG_DATA_W;
  localparam int unsigned EdgeAw    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned EdgeCw    = $clog2(MAX_EDGES + 1);
  localparam int unsigned EdgeWordW = 2 * NODE_W + WEIGHT_BITS;
  localparam int unsigned SumW      = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;

  localparam logic signed [SumW-1:0] DistMax = SumW'((1 << (DIST_W - 1)) - 1);
  localparam logic signed [SumW-1:0] DistMin = -SumW'(1 << (DIST_W - 1));

  spre_state_e state_q, state_d;

  logic [CFG_DATA_W-1:0] node_count_q;
  logic [NODE_W-1:0]     source_node_q;
  logic [EdgeCw-1:0]     edge_total_q, edge_total_d;
  logic                  overflow_q, overflow_d;
  logic [EdgeCw-1:0]     k_q, k_d;
  logic [CntW-1:0]       round_q, round_d;
  logic [CntW-1:0]       idx_q, idx_d;
  logic [MAX_NODES-1:0]  reached_q, reached_d;

  logic                  out_valid_q, out_valid_d;
  spre_result_t          res_q, res_d;
  logic                  out_free;

  logic [CntW-1:0]       nodes;
  logic                  in_xfer;
  logic                  edge_room;

  logic                  edge_we;
  logic [EdgeWordW-1:0]  edge_wdata;
  logic [EdgeWordW-1:0]  edge_rdata;
  logic [NODE_W-1:0]     e_from;
  logic [NODE_W-1:0]     e_to;
  logic [WEIGHT_BITS-1:0] e_weight;

  logic                  dist_we;
  logic [NodeW-1:0]      dist_waddr;
  logic [DIST_W-1:0]     dist_wdata;
  logic [NodeW-1:0]      dist_raddr_a;
  logic [DIST_W-1:0]     dist_u;
  logic [DIST_W-1:0]     dist_v;

  logic [NodeW-1:0]      u_addr;
  logic [NodeW-1:0]      v_addr;
  logic [NodeW-1:0]      src_addr;
  logic [NodeW-1:0]      idx_addr;
  logic                  src_ok;
  logic                  edge_ok;
  logic signed [SumW-1:0] cand;
  logic [DIST_W-1:0]     cand_sat;
  logic                  improve;
  logic                  check_pass;
  logic                  last_k;
  logic                  last_idx;

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q  <= NODE_COUNT_RST;
      source_node_q <= SOURCE_NODE_RST;
    end else if (cfg_valid_i) begin
      unique case (spre_reg_e'(cfg_index_i))
        REG_NODE_COUNT:  node_count_q  <= cfg_data_i;
        REG_SOURCE_NODE: source_node_q <= cfg_data_i[NODE_W-1:0];
        default: ;
      endcase
    end
  end

  // node count clamped to 1..MAX_NODES
  always_comb begin
    if (node_count_q == '0) begin
      nodes = CntW'(1);
    end else if (CntW'(node_count_q) > CntW'(MAX_NODES)) begin
      nodes = CntW'(MAX_NODES);
    end else begin
      nodes = CntW'(node_count_q);
    end
  end

  // -------------------------------------------------------------------------
  // Edge store
  // -------------------------------------------------------------------------
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign edge_room     = (edge_total_q < EdgeCw'(MAX_EDGES));
  assign edge_we       = in_xfer && edge_room;
  assign edge_wdata    = {WEIGHT_BITS'(s_axis_tdata[25:10]),
                          s_axis_tdata[9:5], s_axis_tdata[4:0]};

  spre_ram #(
    .WIDTH (EdgeWordW),
    .DEPTH (MAX_EDGES)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_total_q[EdgeAw-1:0]),
    .wdata_i (edge_wdata),
    .raddr_i (k_q[EdgeAw-1:0]),
    .rdata_o (edge_rdata)
  );

  assign e_from   = edge_rdata[NODE_W-1:0];
  assign e_to     = edge_rdata[2*NODE_W-1:NODE_W];
  assign e_weight = edge_rdata[EdgeWordW-1:2*NODE_W];

  // -------------------------------------------------------------------------
  // Distance store: two copies written together give two read ports
  // -------------------------------------------------------------------------
  assign u_addr   = NodeW'(e_from);
  assign v_addr   = NodeW'(e_to);
  assign src_addr = NodeW'(source_node_q);
  assign idx_addr = idx_q[NodeW-1:0];

  assign dist_raddr_a = ((state_q == S_OUT_RD) || (state_q == S_OUT_LD)) ? idx_addr : u_addr;

  spre_ram #(
    .WIDTH (DIST_W),
    .DEPTH (MAX_NODES)
  ) u_dist_ram_a (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (dist_waddr),
    .wdata_i (dist_wdata),
    .raddr_i (dist_raddr_a),
    .rdata_o (dist_u)
  );

  spre_ram #(
    .WIDTH (DIST_W),
    .DEPTH (MAX_NODES)
  ) u_dist_ram_b (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (dist_waddr),
    .wdata_i (dist_wdata),
    .raddr_i (v_addr),
    .rdata_o (dist_v)
  );

  // -------------------------------------------------------------------------
  // Relaxation datapath
  // -------------------------------------------------------------------------
  assign src_ok  = (CntW'(source_node_q) < nodes);
  assign edge_ok = (CntW'(e_from) < nodes) && (CntW'(e_to) < nodes) && reached_q[u_addr];
  assign cand    = SumW'($signed(dist_u)) + SumW'($signed(e_weight));

  // compare at full width, store saturated
  always_comb begin
    if (cand > DistMax) begin
      cand_sat = DistMax[DIST_W-1:0];
    end else if (cand < DistMin) begin
      cand_sat = DistMin[DIST_W-1:0];
    end else begin
      cand_sat = cand[DIST_W-1:0];
    end
  end

  assign improve    = edge_ok && (!reached_q[v_addr] || (cand < SumW'($signed(dist_v))));
  assign check_pass = (round_q == nodes - CntW'(1));
  assign last_k     = (k_q == edge_total_q - EdgeCw'(1));
  assign last_idx   = (idx_q == nodes - CntW'(1));
  assign out_free   = !out_valid_q || m_axis_tready;

  // -------------------------------------------------------------------------
  // Sequencer
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      edge_total_q <= '0;
      overflow_q   <= 1'b0;
      k_q          <= '0;
      round_q      <= '0;
      idx_q        <= '0;
      reached_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      edge_total_q <= edge_total_d;
      overflow_q   <= overflow_d;
      k_q          <= k_d;
      round_q      <= round_d;
      idx_q        <= idx_d;
      reached_q    <= reached_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_comb begin
    state_d      = state_q;
    edge_total_d = edge_total_q;
    overflow_d   = overflow_q;
    k_d          = k_q;
    round_d      = round_q;
    idx_d        = idx_q;
    reached_d    = reached_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    res_d        = res_q;
    dist_we      = 1'b0;
    dist_waddr   = v_addr;
    dist_wdata   = cand_sat;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (edge_room) begin
            edge_total_d = edge_total_q + EdgeCw'(1);
          end else begin
            overflow_d = 1'b1;
          end
          if (s_axis_tlast) begin
            reached_d = '0;
            if (src_ok) begin
              reached_d[src_addr] = 1'b1;
            end
            dist_we    = src_ok;
            dist_waddr = src_addr;
            dist_wdata = '0;
            k_d        = '0;
            round_d    = '0;
            state_d    = S_RD_EDGE;
          end
        end
      end
      S_RD_EDGE: begin
        state_d = S_RD_DIST;
      end
      S_RD_DIST: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        if (improve && check_pass) begin
          state_d = S_NEG;
        end else begin
          if (improve) begin
            dist_we           = 1'b1;
            reached_d[v_addr] = 1'b1;
          end
          if (last_k) begin
            k_d = '0;
            if (check_pass) begin
              idx_d   = '0;
              state_d = S_OUT_RD;
            end else begin
              round_d = round_q + CntW'(1);
              state_d = S_RD_EDGE;
            end
          end else begin
            k_d     = k_q + EdgeCw'(1);
            state_d = S_RD_EDGE;
          end
        end
      end
      S_NEG: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          res_d.index    = '0;
          res_d.distance = '0;
          res_d.reached  = 1'b0;
          res_d.neg      = 1'b1;
          res_d.dropped  = overflow_q;
          res_d.last     = 1'b1;
          edge_total_d   = '0;
          overflow_d     = 1'b0;
          state_d        = S_IDLE;
        end
      end
      S_OUT_RD: begin
        state_d = S_OUT_LD;
      end
      S_OUT_LD: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          res_d.index    = NODE_W'(idx_q);
          res_d.distance = reached_q[idx_addr] ? dist_u : '0;
          res_d.reached  = reached_q[idx_addr];
          res_d.neg      = 1'b0;
          res_d.dropped  = overflow_q;
          res_d.last     = last_idx;
          if (last_idx) begin
            edge_total_d = '0;
            overflow_d   = 1'b0;
            state_d      = S_IDLE;
          end else begin
            idx_d   = idx_q + CntW'(1);
            state_d = S_OUT_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, res_q.distance, res_q.index};
  assign m_axis_tuser  = {res_q.dropped, res_q.neg, res_q.reached};
  assign m_axis_tlast  = res_q.last;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `ASSERT_IMPLY(a_edge_total_bound, clk_i, rst_ni, 1'b1, edge_total_q <= EdgeCw'(MAX_EDGES), "edge count beyond store depth")
  `ASSERT_IMPLY(a_neg_is_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast && !m_axis_tuser[0], "negative-cycle result not final or marked reached")
  `ASSERT_NEXT(a_neg_ends_run, clk_i, rst_ni, state_q == S_NEG && out_free, state_q == S_IDLE && out_valid_q && edge_total_q == '0, "negative-cycle result did not close the run")

endmodule
